FILE: rtl/assert_macros.svh
// Assertion macros shared by the servo pulse frame sequencer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPFS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SPFS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/spfs_pkg.sv
// Shared types and constants of the servo pulse frame sequencer.
package spfs_pkg;

    typedef logic [1:0] t_op;

    localparam t_op OP_TICK   = 2'd0;
    localparam t_op OP_SET    = 2'd1;
    localparam t_op OP_BOUNDS = 2'd2;
    localparam t_op OP_READ   = 2'd3;

    localparam int MAP_W = 4;

    // Servo number to slot within its chain.
    localparam logic [MAP_W-1:0] SLOT_MAP [16] = '{
        4'd0, 4'd1, 4'd4, 4'd5, 4'd2, 4'd6, 4'd3, 4'd7,
        4'd8, 4'd3, 4'd0, 4'd4, 4'd1, 4'd5, 4'd2, 4'd6
    };

    // Servos below this number drive chain one, the rest chain two.
    localparam logic [3:0] CHAIN_ONE_SERVOS = 4'd9;

    localparam logic [15:0] DEFAULT_WIDTH   = 16'd1500;
    localparam logic [15:0] DEFAULT_LOW     = 16'd1000;
    localparam logic [15:0] DEFAULT_HIGH    = 16'd2000;
    localparam logic [7:0]  TICK_STEP_RST   = 8'd5;
    localparam logic [15:0] DEAD_PERIOD_RST = 16'd20000;

    localparam int APB_AW = 3;

    localparam logic REG_TICK_STEP   = 1'b0;
    localparam logic REG_DEAD_PERIOD = 1'b1;

    // Read request issued to a chain when a word is accepted.
    typedef struct packed {
        logic             en;
        logic             tick;
        logic [MAP_W-1:0] slot;
    } t_rd_req;

    // Action a chain performs when the word in the execute stage retires.
    typedef struct packed {
        logic             tick;
        logic             wr;
        logic [MAP_W-1:0] slot;
        logic [15:0]      data;
    } t_chain_act;

endpackage

FILE: rtl/spfs_if.sv
// Command and result channel interfaces of the servo pulse frame sequencer.
interface spfs_cmd_if;
    import spfs_pkg::*;

    logic        valid;
    logic        ready;
    t_op         op;
    logic [3:0]  servo;
    logic [15:0] position;
    logic [15:0] low_bound;
    logic [15:0] high_bound;

    modport source (output valid, output op, output servo, output position,
                    output low_bound, output high_bound, input ready);
    modport sink (input valid, input op, input servo, input position,
                  input low_bound, input high_bound, output ready);
endinterface

interface spfs_res_if;
    logic        valid;
    logic        ready;
    logic        pulse_chain_one;
    logic        pulse_chain_two;
    logic        status;
    logic [15:0] read_value;

    modport source (output valid, output pulse_chain_one, output pulse_chain_two,
                    output status, output read_value, input ready);
    modport sink (input valid, input pulse_chain_one, input pulse_chain_two,
                  input status, input read_value, output ready);
endinterface

FILE: rtl/spfs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module spfs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 9,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

FILE: rtl/spfs_chain.sv
// One decade-counter chain: width memory, slot sequencer and dead-slot tracking.
`include "assert_macros.svh"

module spfs_chain #(
    parameter int SLOTS = 10
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [7:0]           i_step,
    input  logic [15:0]          i_dead_period,
    input  spfs_pkg::t_rd_req    i_rd,
    input  spfs_pkg::t_chain_act i_act,
    output logic [15:0]          o_width,
    output logic                 o_pulse
);
    import spfs_pkg::*;

    localparam int DEPTH  = SLOTS - 1;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam logic [SLOT_W-1:0] LAST = SLOT_W'(SLOTS - 1);

    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [15:0]       r_elapsed, n_elapsed;
    logic [15:0]       r_dead, n_dead;
    logic [DEPTH-1:0]  r_vld;
    logic              r_fwd;
    logic [15:0]       r_fwd_data;
    logic              r_rdv;
    logic              r_rd_dead;
    logic [15:0]       ram_q;
    logic [15:0]       mem_word;
    logic [15:0]       sum;
    logic              hit;
    logic              at_last;
    logic [4:0]        rd_full;
    logic              rd_dead_now;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;

    // Dead slot lives in r_dead; the memory holds only the servo slots.
    always_comb begin
        mem_word = r_fwd ? r_fwd_data : (r_rdv ? ram_q : DEFAULT_WIDTH);
        o_width  = r_rd_dead ? r_dead : mem_word;
        sum      = r_elapsed + {8'd0, i_step};
        hit      = (sum >= o_width);
        o_pulse  = hit;
        at_last  = (r_slot == LAST);

        n_slot    = r_slot;
        n_elapsed = r_elapsed;
        n_dead    = r_dead;
        if (i_act.tick) begin
            if (hit) begin
                n_elapsed = '0;
                if (at_last) begin
                    n_slot = '0;
                    n_dead = i_dead_period;
                end else begin
                    n_slot = r_slot + SLOT_W'(1);
                    n_dead = r_dead - o_width;
                end
            end else begin
                n_elapsed = sum;
            end
        end
    end

    // A tick reads the slot the chain will sit in once the retiring word is done.
    always_comb begin
        rd_full     = i_rd.tick ? 5'(n_slot) : 5'(i_rd.slot);
        rd_dead_now = i_rd.tick && (n_slot == LAST);
        rd_addr     = (!rd_dead_now && (rd_full < 5'(DEPTH))) ? rd_full[AW-1:0] : '0;
        wr_addr     = i_act.slot[AW-1:0];
    end

    spfs_ram #(
        .WIDTH (16),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_act.wr),
        .i_waddr (wr_addr),
        .i_wdata (i_act.data),
        .i_re    (i_rd.en),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot    <= '0;
            r_elapsed <= '0;
            r_dead    <= DEAD_PERIOD_RST;
            r_vld     <= '0;
            r_fwd     <= 1'b0;
            r_rdv     <= 1'b0;
            r_rd_dead <= 1'b0;
        end else begin
            r_slot    <= n_slot;
            r_elapsed <= n_elapsed;
            r_dead    <= n_dead;
            if (i_act.wr) begin
                r_vld[wr_addr] <= 1'b1;
            end
            if (i_rd.en) begin
                // The memory returns old data when the same entry is written now.
                r_fwd     <= i_act.wr && (wr_addr == rd_addr);
                r_rdv     <= r_vld[rd_addr];
                r_rd_dead <= rd_dead_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_fwd_data <= i_act.data;
        end
    end

    `SPFS_ASSERT_NXT(a_no_tick_holds, i_clk, i_rst_n, !i_act.tick,
        $stable(r_slot) && $stable(r_elapsed) && $stable(r_dead))
    `SPFS_ASSERT_IMP(a_dead_read_matches, i_clk, i_rst_n, i_act.tick, r_rd_dead == at_last)
    `SPFS_ASSERT_IMP(a_slot_in_range, i_clk, i_rst_n, 1'b1, r_slot <= LAST)

endmodule

FILE: rtl/servo_pulse_frame_sequencer.sv
// Servo pulse frame sequencer: two decade-counter chains with bounded position control.
// The block takes one command word per clock unless the output stalls, and returns one
// result word per command via the execute and output registers. Each chain keeps its
// servo slot widths in a single-port-write, registered-read memory that is read once
// when a word is accepted and written when a valid set word retires; a write to the
// entry the next word reads is forwarded, so back-to-back words never wait. The dead
// slot, elapsed time and slot counter sit in registers. Width entries that were never
// written read as 1500 us via per-entry valid bits, so no clearing pass follows reset.
`include "assert_macros.svh"

module servo_pulse_frame_sequencer #(
    parameter int SLOTS_PER_CHAIN = 10,
    parameter int SERVO_COUNT     = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    spfs_cmd_if.sink                    i_cmd,
    spfs_res_if.source                  o_res,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [spfs_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import spfs_pkg::*;

    localparam int SRV_AW = $clog2(SERVO_COUNT);

    logic [7:0]  r_tick_step;
    logic [15:0] r_dead_period;

    logic        r_s1_v;
    t_op         r_s1_op;
    logic [3:0]  r_s1_servo;
    logic [15:0] r_s1_pos;
    logic [15:0] r_s1_lo;
    logic [15:0] r_s1_hi;

    logic        r_out_v;
    logic        r_out_p1;
    logic        r_out_p2;
    logic        r_out_status;
    logic [15:0] r_out_rd;

    logic [15:0] r_lo [SERVO_COUNT];
    logic [15:0] r_hi [SERVO_COUNT];

    logic              accept;
    logic              s1_adv;
    logic              s1_fire;
    logic              cfg_wr;
    logic              srv_ok;
    logic              cell_ok;
    logic              chain_two;
    logic [MAP_W-1:0]  s1_map;
    logic [SRV_AW-1:0] bnd_idx;
    logic [15:0]       cur_lo;
    logic [15:0]       cur_hi;
    logic              set_ok;
    logic [15:0]       w1, w2, w_sel;
    logic              pulse1, pulse2;
    logic              n_status;
    logic [15:0]       n_rd;
    t_rd_req           rd_req;
    t_chain_act        act1, act2;

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_TICK_STEP) ? {24'd0, r_tick_step} : {16'd0, r_dead_period};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_step   <= TICK_STEP_RST;
            r_dead_period <= DEAD_PERIOD_RST;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_TICK_STEP) begin
                r_tick_step <= pwdata[7:0];
            end else begin
                r_dead_period <= pwdata[15:0];
            end
        end
    end

    // Handshake: execute stage feeds the output register.
    assign s1_adv      = !r_out_v || o_res.ready;
    assign s1_fire     = r_s1_v && s1_adv;
    assign i_cmd.ready = !r_s1_v || s1_adv;
    assign accept      = i_cmd.valid && i_cmd.ready;

    assign rd_req.en   = accept;
    assign rd_req.tick = (i_cmd.op == OP_TICK);
    assign rd_req.slot = SLOT_MAP[i_cmd.servo];

    // Execute-stage decode of the addressed servo.
    always_comb begin
        srv_ok    = (5'(r_s1_servo) < 5'(SERVO_COUNT));
        s1_map    = SLOT_MAP[r_s1_servo];
        cell_ok   = srv_ok && (5'(s1_map) < 5'(SLOTS_PER_CHAIN - 1));
        chain_two = (r_s1_servo >= CHAIN_ONE_SERVOS);
        bnd_idx   = srv_ok ? r_s1_servo[SRV_AW-1:0] : '0;
        cur_lo    = r_lo[bnd_idx];
        cur_hi    = r_hi[bnd_idx];
        set_ok    = cell_ok && (r_s1_pos >= cur_lo) && (r_s1_pos <= cur_hi);
        w_sel     = chain_two ? w2 : w1;

        act1.tick = s1_fire && (r_s1_op == OP_TICK);
        act1.wr   = s1_fire && (r_s1_op == OP_SET) && set_ok && !chain_two;
        act1.slot = s1_map;
        act1.data = r_s1_pos;
        act2.tick = act1.tick;
        act2.wr   = s1_fire && (r_s1_op == OP_SET) && set_ok && chain_two;
        act2.slot = s1_map;
        act2.data = r_s1_pos;

        n_status = 1'b0;
        n_rd     = '0;
        unique case (r_s1_op)
            OP_TICK: begin
                n_status = 1'b0;
            end
            OP_SET: begin
                n_status = !set_ok;
            end
            OP_BOUNDS: begin
                n_status = !srv_ok;
            end
            OP_READ: begin
                n_status = !cell_ok;
                n_rd     = cell_ok ? w_sel : '0;
            end
            default: begin
                n_status = 1'b1;
            end
        endcase
    end

    spfs_chain #(
        .SLOTS (SLOTS_PER_CHAIN)
    ) u_chain_one (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (r_tick_step),
        .i_dead_period (r_dead_period),
        .i_rd          (rd_req),
        .i_act         (act1),
        .o_width       (w1),
        .o_pulse       (pulse1)
    );

    spfs_chain #(
        .SLOTS (SLOTS_PER_CHAIN)
    ) u_chain_two (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (r_tick_step),
        .i_dead_period (r_dead_period),
        .i_rd          (rd_req),
        .i_act         (act2),
        .o_width       (w2),
        .o_pulse       (pulse2)
    );

    // Control state and bound tables.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_out_v <= 1'b0;
            for (int i = 0; i < SERVO_COUNT; i++) begin
                r_lo[i] <= DEFAULT_LOW;
                r_hi[i] <= DEFAULT_HIGH;
            end
        end else begin
            if (accept) begin
                r_s1_v <= 1'b1;
            end else if (s1_fire) begin
                r_s1_v <= 1'b0;
            end
            if (s1_fire) begin
                r_out_v <= 1'b1;
            end else if (o_res.ready) begin
                r_out_v <= 1'b0;
            end
            if (s1_fire && (r_s1_op == OP_BOUNDS) && srv_ok) begin
                r_lo[bnd_idx] <= r_s1_lo;
                r_hi[bnd_idx] <= r_s1_hi;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_op    <= i_cmd.op;
            r_s1_servo <= i_cmd.servo;
            r_s1_pos   <= i_cmd.position;
            r_s1_lo    <= i_cmd.low_bound;
            r_s1_hi    <= i_cmd.high_bound;
        end
        if (s1_fire) begin
            r_out_p1     <= act1.tick && pulse1;
            r_out_p2     <= act2.tick && pulse2;
            r_out_status <= n_status;
            r_out_rd     <= n_rd;
        end
    end

    assign o_res.valid           = r_out_v;
    assign o_res.pulse_chain_one = r_out_p1;
    assign o_res.pulse_chain_two = r_out_p2;
    assign o_res.status          = r_out_status;
    assign o_res.read_value      = r_out_rd;

    `SPFS_ASSERT_NXT(a_s1_hold, i_clk, i_rst_n, r_s1_v && !s1_adv,
        r_s1_v && $stable(r_s1_op) && $stable(r_s1_servo) && $stable(r_s1_pos))
    `SPFS_ASSERT_NXT(a_tick_result_clean, i_clk, i_rst_n, s1_fire && (r_s1_op == OP_TICK),
        r_out_v && !r_out_status && (r_out_rd == 16'd0))
    `SPFS_ASSERT_IMP(a_single_chain_write, i_clk, i_rst_n, 1'b1, !(act1.wr && act2.wr))

endmodule

FILE: sim/servo_pulse_frame_sequencer_tb.sv
// Self-checking testbench of the servo pulse frame sequencer with a built-in predictor.
module servo_pulse_frame_sequencer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import spfs_pkg::*;

    localparam int SLOTS     = 10;
    localparam int SERVOS    = 16;
    localparam int DEAD_SLOT = SLOTS - 1;

    typedef struct packed {
        logic        pulse_one;
        logic        pulse_two;
        logic        status;
        logic [15:0] read_value;
    } t_servo_result;

    logic                i_clk;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    spfs_cmd_if cmd_ch();
    spfs_res_if res_ch();

    servo_pulse_frame_sequencer #(
        .SLOTS_PER_CHAIN(SLOTS),
        .SERVO_COUNT    (SERVOS)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd_ch),
        .o_res  (res_ch),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    // Predicted state of the sequencer.
    logic [7:0]  tick_step_q;
    logic [15:0] dead_period_q;
    logic [15:0] slot_width [2][SLOTS];
    logic [15:0] elapsed_us [2];
    logic [3:0]  slot_idx [2];
    logic [15:0] low_limit [SERVOS];
    logic [15:0] high_limit [SERVOS];

    t_servo_result expected_results [$];
    int            mismatch_count = 0;

    int   pending_gap = 0;
    bit   tx_dense    = 0;
    bit   force_dense = 0;
    bit   rx_dense    = 0;
    logic rx_hold     = 1'b0;
    int   hold_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("servo_pulse_frame_sequencer_tb: done, errors");
        $finish;
    end

    // One chain on one tick; returns the clock pulse to its decade counter.
    function automatic logic clock_chain(int c);
        logic [3:0]  s;
        logic [15:0] w;
        s = slot_idx[c];
        if (s >= SLOTS) s = '0;
        elapsed_us[c] = elapsed_us[c] + 16'(tick_step_q);
        w = slot_width[c][s];
        if (elapsed_us[c] < w) return 1'b0;
        elapsed_us[c] = '0;
        // The dead slot shrinks by every width; on itself it reaches zero, then reloads.
        slot_width[c][DEAD_SLOT] = slot_width[c][DEAD_SLOT] - w;
        if (s >= DEAD_SLOT) begin
            slot_idx[c] = '0;
            slot_width[c][DEAD_SLOT] = dead_period_q;
        end else begin
            slot_idx[c] = s + 4'd1;
        end
        return 1'b1;
    endfunction

    function automatic t_servo_result predict_word(t_op op, logic [3:0] servo,
                                                   logic [15:0] pos, logic [15:0] lo,
                                                   logic [15:0] hi);
        t_servo_result r;
        int            c;
        int            s;
        r = '0;
        c = (servo < CHAIN_ONE_SERVOS) ? 0 : 1;
        s = SLOT_MAP[servo];
        case (op)
            OP_TICK: begin
                r.pulse_one = clock_chain(0);
                r.pulse_two = clock_chain(1);
            end
            OP_SET: begin
                if (s < DEAD_SLOT && pos >= low_limit[servo] && pos <= high_limit[servo])
                    slot_width[c][s] = pos;
                else
                    r.status = 1'b1;
            end
            OP_BOUNDS: begin
                low_limit[servo]  = lo;
                high_limit[servo] = hi;
            end
            OP_READ: begin
                if (s < DEAD_SLOT) r.read_value = slot_width[c][s];
                else r.status = 1'b1;
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic note_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= 10) $display("mismatch: %s", msg);
    endtask

    // Offers one word, waits for it to be taken and records its expected result.
    task automatic send_word(t_op op, logic [3:0] servo, logic [15:0] pos,
                             logic [15:0] lo, logic [15:0] hi);
        repeat (pending_gap) @(posedge i_clk);
        cmd_ch.valid      <= 1'b1;
        cmd_ch.op         <= op;
        cmd_ch.servo      <= servo;
        cmd_ch.position   <= pos;
        cmd_ch.low_bound  <= lo;
        cmd_ch.high_bound <= hi;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        expected_results.push_back(predict_word(op, servo, pos, lo, hi));
        if ($urandom_range(0, 31) == 0) tx_dense = !tx_dense;
        pending_gap = (tx_dense || force_dense) ? 0 : $urandom_range(0, 8);
        // Valid stays high only when the next word follows at once.
        if (pending_gap != 0) cmd_ch.valid <= 1'b0;
    endtask

    task automatic send_tick();
        send_word(OP_TICK, 4'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    task automatic send_random_word();
        t_op         op;
        logic [3:0]  servo;
        logic [15:0] pos;
        logic [15:0] lo;
        logic [15:0] hi;
        int          pick;
        pick  = $urandom_range(0, 99);
        op    = pick < 45 ? OP_TICK : pick < 75 ? OP_SET : pick < 87 ? OP_BOUNDS : OP_READ;
        servo = 4'($urandom);
        pos   = 16'($urandom);
        lo    = 16'($urandom);
        hi    = 16'($urandom);
        if (op == OP_SET) begin
            case ($urandom_range(0, 9))
                0: pos = low_limit[servo];
                1: pos = high_limit[servo];
                2: pos = low_limit[servo] - 16'd1;
                3: pos = high_limit[servo] + 16'd1;
                4, 5: ;
                default: begin
                    if (low_limit[servo] <= high_limit[servo])
                        pos = low_limit[servo] +
                              16'($urandom_range(0, high_limit[servo] - low_limit[servo]));
                end
            endcase
        end else if (op == OP_BOUNDS && $urandom_range(0, 4) != 0) begin
            // Mostly narrow, low windows so that chains keep cycling through frames.
            lo = 16'($urandom_range(0, 200));
            hi = lo + 16'($urandom_range(0, 300));
        end
        send_word(op, servo, pos, lo, hi);
    endtask

    // Stops offering words and waits until every result has come back.
    task automatic drain_results();
        if (pending_gap == 0) cmd_ch.valid <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0);
        pending_gap = 0;
    endtask

    // Writes a register while the block is idle, then reads it back.
    task automatic write_register(logic idx, logic [31:0] value);
        logic [31:0] want;
        drain_results();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (idx == REG_TICK_STEP) tick_step_q = value[7:0];
        else dead_period_q = value[15:0];
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        want = (idx == REG_TICK_STEP) ? {24'd0, tick_step_q} : {16'd0, dead_period_q};
        if (prdata !== want)
            note_mismatch($sformatf("register %0d read back expected %0d, got %0d",
                                    idx, want, prdata));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic test_default_state();
        send_word(OP_READ, 4'd0, 16'd0, 16'd0, 16'd0);
        send_word(OP_READ, 4'd8, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_word(OP_READ, 4'd9, 16'd0, 16'd0, 16'd0);
        send_word(OP_READ, 4'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        // Both limits are inside the window, one past each is not.
        send_word(OP_SET, 4'd3, 16'd999, 16'd0, 16'd0);
        send_word(OP_SET, 4'd3, 16'd1000, 16'd0, 16'd0);
        send_word(OP_SET, 4'd3, 16'd2000, 16'd0, 16'd0);
        send_word(OP_SET, 4'd3, 16'd2001, 16'd0, 16'd0);
        send_word(OP_READ, 4'd3, 16'd0, 16'd0, 16'd0);
        repeat (3) send_tick();
    endtask

    task automatic test_bounds();
        // An inverted window rejects every position.
        send_word(OP_BOUNDS, 4'd5, 16'd0, 16'd2000, 16'd1000);
        send_word(OP_SET, 4'd5, 16'd1500, 16'd0, 16'd0);
        send_word(OP_BOUNDS, 4'd12, 16'd0, 16'd0, 16'hFFFF);
        send_word(OP_SET, 4'd12, 16'd0, 16'd0, 16'd0);
        send_word(OP_SET, 4'd12, 16'hFFFF, 16'd0, 16'd0);
        send_word(OP_READ, 4'd12, 16'd0, 16'd0, 16'd0);
        send_word(OP_BOUNDS, 4'd12, 16'd0, 16'd777, 16'd777);
        send_word(OP_SET, 4'd12, 16'd777, 16'd0, 16'd0);
        send_word(OP_SET, 4'd12, 16'd778, 16'd0, 16'd0);
        send_word(OP_READ, 4'd12, 16'd0, 16'd0, 16'd0);
    endtask

    task automatic test_registers();
        write_register(REG_TICK_STEP, 32'd255);
        write_register(REG_DEAD_PERIOD, 32'd65535);
        repeat (3) send_tick();
        write_register(REG_TICK_STEP, 32'd1);
        write_register(REG_DEAD_PERIOD, 32'd0);
        repeat (3) send_tick();
        write_register(REG_TICK_STEP, 32'(TICK_STEP_RST));
        write_register(REG_DEAD_PERIOD, 32'(DEAD_PERIOD_RST));
    endtask

    // Short widths and a fast tick so that chains run through whole frames,
    // and a dead period change that only shows after the next frame wrap.
    task automatic test_frame_wrap();
        write_register(REG_TICK_STEP, 32'd255);
        write_register(REG_DEAD_PERIOD, 32'd300);
        for (int s = 0; s < SERVOS; s++)
            send_word(OP_BOUNDS, 4'(s), 16'($urandom), 16'd0, 16'hFFFF);
        for (int s = 0; s < SERVOS; s++)
            send_word(OP_SET, 4'(s), 16'($urandom_range(0, 40)), 16'($urandom),
                      16'($urandom));
        repeat (120) send_tick();
        write_register(REG_DEAD_PERIOD, 32'd1000);
        repeat (80) send_tick();
    endtask

    // Widest slots with a step that misses 65535, so the elapsed time wraps.
    task automatic test_elapsed_wrap();
        write_register(REG_TICK_STEP, 32'd254);
        for (int s = 0; s < SERVOS; s++)
            send_word(OP_SET, 4'(s), 16'hFFFF, 16'($urandom), 16'($urandom));
        repeat (270) send_tick();
    endtask

    task automatic test_backpressure();
        drain_results();
        hold_cycles = 150;
        force_dense = 1;
        repeat (60) send_random_word();
        force_dense = 0;
        drain_results();
    endtask

    task automatic test_random();
        int          step_set [6] = '{1, 255, 2, 255, 0, 100};
        int          dead_set [6] = '{0, 65535, 150, 0, 0, 3000};
        logic [31:0] step;
        logic [31:0] dead;
        for (int p = 0; p < 6; p++) begin
            step = (p == 4) ? $urandom_range(1, 255) : step_set[p];
            dead = (p == 4) ? $urandom_range(0, 65535) : dead_set[p];
            write_register(REG_TICK_STEP, step);
            write_register(REG_DEAD_PERIOD, dead);
            if (p == 0) begin
                for (int s = 0; s < SERVOS; s++) begin
                    send_word(OP_BOUNDS, 4'(s), 16'($urandom), 16'd0, 16'd400);
                    send_word(OP_SET, 4'(s), 16'($urandom_range(0, 400)), 16'($urandom),
                              16'($urandom));
                end
            end
            repeat (50) send_random_word();
        end
    endtask

    initial begin
        i_rst_n            = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        cmd_ch.valid       = 1'b0;
        cmd_ch.op          = OP_TICK;
        cmd_ch.servo       = '0;
        cmd_ch.position    = '0;
        cmd_ch.low_bound   = '0;
        cmd_ch.high_bound  = '0;
        tick_step_q        = TICK_STEP_RST;
        dead_period_q      = DEAD_PERIOD_RST;
        for (int c = 0; c < 2; c++) begin
            for (int s = 0; s < SLOTS; s++) slot_width[c][s] = DEFAULT_WIDTH;
            slot_width[c][DEAD_SLOT] = dead_period_q;
            elapsed_us[c] = '0;
            slot_idx[c]   = '0;
        end
        for (int s = 0; s < SERVOS; s++) begin
            low_limit[s]  = DEFAULT_LOW;
            high_limit[s] = DEFAULT_HIGH;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_state();
        test_bounds();
        test_registers();
        test_frame_wrap();
        test_elapsed_wrap();
        test_backpressure();
        test_random();

        drain_results();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("servo_pulse_frame_sequencer_tb: done, clean");
        end else begin
            $display("servo_pulse_frame_sequencer_tb: done, errors");
        end
        $finish;
    end

    // Long hold-off of the result side, counted here in clock cycles.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_cycles != 0) begin
                rx_hold <= 1'b1;
                repeat (hold_cycles) @(posedge i_clk);
                rx_hold <= 1'b0;
                hold_cycles = 0;
            end
        end
    end

    // Result side: a random stall before each word, with stretches of none.
    initial begin
        int stall;
        res_ch.ready = 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            stall = rx_dense ? 0 : $urandom_range(0, 8);
            if (stall != 0 || rx_hold) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
                while (rx_hold) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!res_ch.valid);
            if ($urandom_range(0, 23) == 0) rx_dense = !rx_dense;
        end
    end

    always @(posedge i_clk) begin
        t_servo_result want;
        t_servo_result got;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got = '{res_ch.pulse_chain_one, res_ch.pulse_chain_two, res_ch.status,
                    res_ch.read_value};
            if (expected_results.size() == 0) begin
                note_mismatch($sformatf("result with none expected: p1=%0b p2=%0b st=%0b rd=%0d",
                                        got.pulse_one, got.pulse_two, got.status,
                                        got.read_value));
            end else begin
                want = expected_results.pop_front();
                if (got.pulse_one !== want.pulse_one || got.pulse_two !== want.pulse_two ||
                    got.status !== want.status || got.read_value !== want.read_value)
                    note_mismatch($sformatf(
                        "expected p1=%0b p2=%0b st=%0b rd=%0d, got p1=%0b p2=%0b st=%0b rd=%0d",
                        want.pulse_one, want.pulse_two, want.status, want.read_value,
                        got.pulse_one, got.pulse_two, got.status, got.read_value));
            end
        end
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/spfs_pkg.sv
rtl/spfs_if.sv
rtl/spfs_ram.sv
rtl/spfs_chain.sv
rtl/servo_pulse_frame_sequencer.sv
sim/servo_pulse_frame_sequencer_tb.sv
